### design/mean_value_coordinate_weights_assert.svh
// assertion macros for the mean value coordinate weights block
`ifndef MEAN_VALUE_COORDINATE_WEIGHTS_ASSERT_SVH
`define MEAN_VALUE_COORDINATE_WEIGHTS_ASSERT_SVH
// implication checked on every clock edge outside reset
`define MVC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
// next-cycle implication outside reset
`define MVC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`endif

### design/mvcw_pkg.sv
// shared types and constants for the mean value coordinate weights block
`timescale 1ns / 1ps
package mvcw_pkg;
   localparam int MaxVertices = 16;
   localparam int CoordWidth  = 32;
   localparam logic [4:0]  VertexCountReset = 5'd4;
   localparam logic [15:0] CoincideReset    = 16'd66;
   localparam logic [0:0] CsrVertexCount = 1'b0;
   localparam logic [0:0] CsrCoincide    = 1'b1;
   localparam logic ActLoad  = 1'b0;
   localparam logic ActQuery = 1'b1;
   localparam logic [43:0] TanMax = {44{1'b1}};
   localparam logic [47:0] RawMax = {48{1'b1}};

   typedef struct packed {
      logic              action;
      logic [3:0]        vertex_index;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
   } req_type;

   typedef struct packed {
      logic [30:0] weight;
      logic [3:0]  weight_index;
      logic        coincident;
      logic        last;
   } rsp_type;

   // divider request and reply
   typedef struct packed {
      logic        start;
      logic [79:0] num;
      logic [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [79:0] quo;
   } div_rsp_type;
endpackage

### design/mean_value_coordinate_weights.sv
// mean value coordinate weights: top level with vertex and weight memories and sequencer
// a load is stored at its accepting edge and never raises busy; loads go one per cycle while idle
// a query steps through every vertex with the shared divider and square root, and skips
// the weight passes when the point hits a vertex; one query at a time
// weights leave one per divide, coincident words every cycle; the receiver cannot stall
// synchronous active-high reset; vertex and weight memories are not cleared
`timescale 1ns / 1ps
module mean_value_coordinate_weights import mvcw_pkg::*; #(
   parameter int MAX_VERTICES = MaxVertices,
   parameter int COORD_WIDTH  = CoordWidth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);
   `include "mean_value_coordinate_weights_assert.svh"

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CntMax = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
   localparam int CW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

   localparam logic [4:0] S_IDLE = 5'd0,  S_RD = 5'd1,   S_LEN = 5'd2,  S_LENW = 5'd3,
                          S_U = 5'd4,     S_UW = 5'd5,   S_NEXTV = 5'd6, S_WRD = 5'd7,
                          S_WRD2 = 5'd8,  S_CR = 5'd9,   S_CR2 = 5'd10, S_NUM = 5'd11,
                          S_NUMW = 5'd12, S_TAN = 5'd13, S_TANW = 5'd14, S_RAW = 5'd15,
                          S_RAWW = 5'd16, S_ORD = 5'd17, S_ORD2 = 5'd18, S_OUTW = 5'd19,
                          S_COIN = 5'd20;

   // memories: cage coordinates, unit vectors plus length, raw weights
   logic signed [31:0] cx_mem [MAX_VERTICES];
   logic signed [31:0] cy_mem [MAX_VERTICES];
   logic signed [31:0] cz_mem [MAX_VERTICES];
   logic [127:0]       u_mem  [MAX_VERTICES];
   logic [47:0]        rw_mem [MAX_VERTICES];

   logic [4:0]  st_ff, st_in;
   logic [4:0]  vcnt_ff;
   logic [15:0] cdist_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic [4:0]  n_ff, i_ff, i_in;
   logic [4:0]  hit_ff, hit_in;
   logic        hitv_ff, hitv_in;
   logic [55:0] sum_ff, sum_in;
   logic [1:0]  k_ff, k_in;
   logic        h_ff, h_in;
   logic signed [31:0] rx_ff, ry_ff, rz_ff;
   logic [31:0] len_ff;
   logic [31:0] ucomp_ff [3];
   logic [43:0] tan_ff;
   logic [45:0] tsum_ff;
   logic signed [31:0] a_ff [3];
   logic signed [31:0] b_ff [3];
   logic [31:0] cr_ff [3];
   logic signed [63:0] dot_ff;

   // memory ports
   logic [AW-1:0] crd_addr;
   logic signed [31:0] crd_x, crd_y, crd_z;
   logic [AW-1:0] urd_addr;
   logic [127:0] urd;
   logic         uwe;
   logic [AW-1:0] uwa;
   logic [127:0] uwd;
   logic         rwe;
   logic [AW-1:0] rwa, rra;
   logic [47:0]  rwd, rrd;

   logic        sq_start, sq_done;
   logic [63:0] sq_val;
   logic [31:0] sq_root;
   div_req_type dreq;
   div_rsp_type drsp;

   logic        rv_ff, rv_in;
   rsp_type     rd_ff, rd_in;

   mvcw_sqrt u_sqrt (.clock, .reset, .start(sq_start), .value(sq_val),
      .done(sq_done), .root(sq_root));
   mvcw_div u_div (.clock, .reset, .req(dreq), .rsp(drsp));

   logic signed [31:0] sx, sy, sz;
   logic signed [32:0] dx, dy, dz;
   logic signed [31:0] tx, ty, tz;
   logic [31:0] mx, my, mz;
   logic [65:0] ssum;
   logic        ld;
   logic [4:0]  nclamp;
   logic [31:0] mr;
   logic signed [31:0] rk;
   logic [AW-1:0] prv, nxt, iw;

   function automatic logic signed [31:0] satd(input logic signed [32:0] d);
      if (d > 33'sd2147483647) return 32'sh7fffffff;
      else if (d < -33'sd2147483648) return 32'sh80000000;
      else return d[31:0];
   endfunction

   function automatic logic signed [31:0] sx32(input logic [31:0] v);
      logic [31:0] m;
      m = v << (32 - CW);
      return $signed(m) >>> (32 - CW);
   endfunction

   function automatic logic [95:0] u_mem_pack(input logic [31:0] a, b, c);
      return {a, b, c};
   endfunction

   function automatic logic [31:0] absr(input logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? 64'(-v) : 64'(v);
      return 32'(m >> 30);
   endfunction

   always_comb begin
      sx = sx32(req_data.coord_x);
      sy = sx32(req_data.coord_y);
      sz = sx32(req_data.coord_z);
      ld = start && !busy && req_data.action == ActLoad;
      nclamp = (vcnt_ff < 5'd3) ? 5'd3 : (vcnt_ff > 5'(CntMax)) ? 5'(CntMax) : vcnt_ff;
      dx = 33'(crd_x) - 33'(px_ff);
      dy = 33'(crd_y) - 33'(py_ff);
      dz = 33'(crd_z) - 33'(pz_ff);
      tx = satd(dx);
      ty = satd(dy);
      tz = satd(dz);
      mx = tx[31] ? 32'(-tx) : 32'(tx);
      my = ty[31] ? 32'(-ty) : 32'(ty);
      mz = tz[31] ? 32'(-tz) : 32'(tz);
      ssum = 66'(64'(mx) * 64'(mx)) + 66'(64'(my) * 64'(my)) + 66'(64'(mz) * 64'(mz));
      rk = (k_ff == 2'd0) ? rx_ff : (k_ff == 2'd1) ? ry_ff : rz_ff;
      mr = rk[31] ? 32'(-rk) : 32'(rk);
      iw  = i_ff[AW-1:0];
      prv = (i_ff == 5'd0) ? AW'(n_ff - 5'd1) : AW'(i_ff - 5'd1);
      nxt = (i_ff == n_ff - 5'd1) ? '0 : AW'(i_ff + 5'd1);
   end

   // cage store
   always_ff @(posedge clock) begin
      if (ld && 32'(req_data.vertex_index) < MAX_VERTICES) begin
         cx_mem[AW'(req_data.vertex_index)] <= sx;
         cy_mem[AW'(req_data.vertex_index)] <= sy;
         cz_mem[AW'(req_data.vertex_index)] <= sz;
      end
      crd_x <= cx_mem[crd_addr];
      crd_y <= cy_mem[crd_addr];
      crd_z <= cz_mem[crd_addr];
   end

   always_ff @(posedge clock) begin
      if (uwe) u_mem[uwa] <= uwd;
      urd <= u_mem[urd_addr];
   end

   always_ff @(posedge clock) begin
      if (rwe) rw_mem[rwa] <= rwd;
      rrd <= rw_mem[rra];
   end

   always_comb begin
      st_in = st_ff; i_in = i_ff; hit_in = hit_ff; hitv_in = hitv_ff; sum_in = sum_ff;
      k_in = k_ff; h_in = h_ff;
      crd_addr = iw; urd_addr = iw; uwe = 1'b0; uwa = iw;
      uwd = {u_mem_pack(ucomp_ff[0], ucomp_ff[1], ucomp_ff[2]), len_ff};
      rwe = 1'b0; rwa = iw; rwd = '0; rra = iw;
      sq_start = 1'b0; sq_val = '0; dreq = '0;
      rv_in = 1'b0; rd_in = rd_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (start && req_data.action == ActQuery) begin
               i_in = '0; hitv_in = 1'b0; st_in = S_RD;
            end
         end
         S_RD: st_in = S_LEN;
         S_LEN: begin
            if (!hitv_ff && ssum < 66'(32'(cdist_ff) * 32'(cdist_ff))) begin
               hitv_in = 1'b1; hit_in = i_ff;
            end
            sq_start = 1'b1; sq_val = ssum[63:0]; st_in = S_LENW;
         end
         S_LENW: if (sq_done) begin k_in = '0; st_in = S_U; end
         S_U: begin
            dreq.start = 1'b1;
            dreq.num = 80'(mr) << 30;
            dreq.den = (len_ff == '0) ? 64'd1 : 64'(len_ff);
            st_in = S_UW;
         end
         S_UW: if (drsp.done) begin
            if (k_ff == 2'd2) st_in = S_NEXTV;
            else begin k_in = k_ff + 2'd1; st_in = S_U; end
         end
         S_NEXTV: begin
            uwe = 1'b1;
            if (i_ff == n_ff - 5'd1) begin
               i_in = '0;
               sum_in = hitv_ff ? sum_ff : '0;
               st_in = hitv_ff ? S_COIN : S_WRD;
            end else begin
               i_in = i_ff + 5'd1; st_in = S_RD;
            end
         end
         S_WRD: begin urd_addr = prv; h_in = 1'b0; st_in = S_WRD2; end
         S_WRD2: begin urd_addr = h_ff ? nxt : iw; st_in = S_CR; end
         S_CR: st_in = S_CR2;
         S_CR2: st_in = S_NUM;
         S_NUM: begin
            sq_start = 1'b1;
            sq_val = 64'(cr_ff[0]) * 64'(cr_ff[0]) + 64'(cr_ff[1]) * 64'(cr_ff[1])
                   + 64'(cr_ff[2]) * 64'(cr_ff[2]);
            st_in = S_NUMW;
         end
         S_NUMW: if (sq_done) st_in = S_TAN;
         S_TAN: begin
            dreq.start = 1'b1;
            dreq.num = 80'(sq_root) << 30;
            dreq.den = (dot_ff <= 0) ? 64'd1 : 64'(dot_ff >>> 30);
            st_in = S_TANW;
         end
         S_TANW: if (drsp.done) begin
            if (!h_ff) begin
               h_in = 1'b1; urd_addr = iw; st_in = S_WRD2;
            end else st_in = S_RAW;
         end
         S_RAW: begin
            dreq.start = 1'b1;
            dreq.num = 80'(tsum_ff + 46'(tan_ff)) << 17;
            dreq.den = (len_ff == '0) ? 64'd1 : 64'(len_ff);
            st_in = S_RAWW;
         end
         S_RAWW: if (drsp.done) begin
            rwe = 1'b1;
            rwd = (len_ff == '0 || drsp.quo > 80'(RawMax)) ? RawMax : drsp.quo[47:0];
            sum_in = sum_ff + 56'(rwd);
            if (i_ff == n_ff - 5'd1) begin i_in = '0; st_in = S_ORD; end
            else begin i_in = i_ff + 5'd1; st_in = S_WRD; end
         end
         S_ORD: st_in = S_ORD2;
         S_ORD2: begin
            dreq.start = 1'b1;
            dreq.num = 80'(rrd) << 30;
            dreq.den = (sum_ff == '0) ? 64'd1 : 64'(sum_ff);
            st_in = S_OUTW;
         end
         S_OUTW: if (drsp.done) begin
            rv_in = 1'b1;
            rd_in.weight = (sum_ff == '0) ? '0 : drsp.quo[30:0];
            rd_in.weight_index = i_ff[3:0];
            rd_in.coincident = 1'b0;
            rd_in.last = (i_ff == n_ff - 5'd1);
            if (i_ff == n_ff - 5'd1) st_in = S_IDLE;
            else begin i_in = i_ff + 5'd1; st_in = S_ORD; end
         end
         S_COIN: begin
            rv_in = 1'b1;
            rd_in.weight = (i_ff == hit_ff) ? 31'h4000_0000 : '0;
            rd_in.weight_index = i_ff[3:0];
            rd_in.coincident = 1'b1;
            rd_in.last = (i_ff == n_ff - 5'd1);
            if (i_ff == n_ff - 5'd1) st_in = S_IDLE;
            else i_in = i_ff + 5'd1;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; vcnt_ff <= VertexCountReset; cdist_ff <= CoincideReset;
         sum_ff <= '0; rv_ff <= 1'b0; i_ff <= '0; hitv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; sum_ff <= sum_in; rv_ff <= rv_in; i_ff <= i_in;
         hitv_ff <= hitv_in;
         if (csr_valid && csr_ready && csr_index == CsrVertexCount)
            vcnt_ff <= csr_data[4:0];
         if (csr_valid && csr_ready && csr_index == CsrCoincide)
            cdist_ff <= csr_data[15:0];
      end
      hit_ff <= hit_in; k_ff <= k_in; h_ff <= h_in; rd_ff <= rd_in;
      if (st_ff == S_IDLE && start) begin
         px_ff <= sx; py_ff <= sy; pz_ff <= sz; n_ff <= nclamp;
      end
      if (st_ff == S_LEN) begin
         rx_ff <= tx; ry_ff <= ty; rz_ff <= tz;
      end
      if (st_ff == S_LENW && sq_done) len_ff <= sq_root;
      if (st_ff == S_UW && drsp.done)
         ucomp_ff[k_ff] <= (len_ff == '0) ? '0 :
            (rk[31] ? 32'(-drsp.quo[31:0]) : drsp.quo[31:0]);
      // unit vector reads: first a, then b
      if (st_ff == S_WRD2) begin
         a_ff[0] <= urd[127:96]; a_ff[1] <= urd[95:64]; a_ff[2] <= urd[63:32];
      end
      if (st_ff == S_CR) begin
         b_ff[0] <= urd[127:96]; b_ff[1] <= urd[95:64]; b_ff[2] <= urd[63:32];
         if (!h_ff) len_ff <= urd[31:0];
      end
      if (st_ff == S_CR2) begin
         cr_ff[0] <= absr(64'(a_ff[1]) * 64'(b_ff[2]) - 64'(a_ff[2]) * 64'(b_ff[1]));
         cr_ff[1] <= absr(64'(a_ff[2]) * 64'(b_ff[0]) - 64'(a_ff[0]) * 64'(b_ff[2]));
         cr_ff[2] <= absr(64'(a_ff[0]) * 64'(b_ff[1]) - 64'(a_ff[1]) * 64'(b_ff[0]));
         dot_ff <= 64'sh1000_0000_0000_0000 + 64'(a_ff[0]) * 64'(b_ff[0])
                 + 64'(a_ff[1]) * 64'(b_ff[1]) + 64'(a_ff[2]) * 64'(b_ff[2]);
      end
      if (st_ff == S_TANW && drsp.done) begin
         tan_ff <= (dot_ff <= 0 || drsp.quo > 80'(TanMax)) ? TanMax : drsp.quo[43:0];
         if (!h_ff) tsum_ff <= '0;
      end
      if (st_ff == S_RAW) tsum_ff <= tsum_ff + 46'(tan_ff);
      if (st_ff == S_TAN && h_ff) tsum_ff <= tsum_ff + 46'(tan_ff);
   end

   assign busy      = (st_ff != S_IDLE);
   assign csr_ready = !busy;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;

   `MVC_ASSERT_IMP(a_rsp_busy, clock, reset, rv_in, busy)
   `MVC_ASSERT_NXT(a_last_idle, clock, reset, rv_ff && rd_ff.last, st_ff == S_IDLE || busy)
   `MVC_ASSERT_IMP(a_idx_range, clock, reset, rv_ff, {1'b0, rd_ff.weight_index} < n_ff)
endmodule

### design/mvcw_sqrt.sv
// iterative digit-by-digit integer square root; a new start restarts any root in progress
`timescale 1ns / 1ps
module mvcw_sqrt import mvcw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] v_ff, v_in, r_ff, r_in, b_ff, b_in;
   logic        run_ff, run_in, done_ff, done_in;

   always_comb begin
      v_in = v_ff; r_in = r_ff; b_in = b_ff; run_in = run_ff; done_in = 1'b0;
      if (start) begin
         v_in = value; r_in = '0; b_in = 64'h4000_0000_0000_0000; run_in = 1'b1;
      end else if (run_ff) begin
         if (b_ff == '0) begin
            run_in = 1'b0; done_in = 1'b1;
         end else if (b_ff > v_ff && r_ff == '0) begin
            b_in = b_ff >> 2;
         end else begin
            if (v_ff >= r_ff + b_ff) begin
               v_in = v_ff - (r_ff + b_ff);
               r_in = (r_ff >> 1) + b_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            b_in = b_ff >> 2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
      v_ff <= v_in; r_ff <= r_in; b_ff <= b_in;
   end

   assign done = done_ff;
   assign root = r_ff[31:0];
endmodule

### design/mvcw_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module mvcw_div import mvcw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic [79:0] q_ff, q_in;
   logic [80:0] rem_ff, rem_in;
   logic [63:0] d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, done_ff, done_in;
   logic [80:0] sh;

   always_comb begin
      q_in = q_ff; rem_in = rem_ff; d_in = d_ff; cnt_in = cnt_ff;
      run_in = run_ff; done_in = 1'b0;
      sh = '0;
      if (req.start) begin
         q_in = req.num; rem_in = '0; d_in = req.den; cnt_in = 7'd80; run_in = 1'b1;
      end else if (run_ff) begin
         sh = {rem_ff[79:0], q_ff[79]};
         if (sh >= {17'd0, d_ff}) begin
            rem_in = sh - {17'd0, d_ff};
            q_in = {q_ff[78:0], 1'b1};
         end else begin
            rem_in = sh;
            q_in = {q_ff[78:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         run_ff <= run_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; rem_ff <= rem_in; d_ff <= d_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = q_ff;
endmodule
